// ===== hdl/bps_pkg.sv =====
// Shared types, codes and constants of the board power sequencer.
package bps_pkg;

    localparam int unsigned CFG_WIDTH = 16;
    localparam int unsigned CFG_INDEX_WIDTH = 2;
    localparam int unsigned PHASE_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ONE_SECOND  = 2'd0,
        CFG_HALF_SECOND = 2'd1,
        CFG_STEP_DELAY  = 2'd2,
        CFG_LONG_PRESS  = 2'd3
    } cfg_index_t;

    localparam logic [CFG_WIDTH-1:0] RESET_ONE_SECOND  = 16'd100;
    localparam logic [CFG_WIDTH-1:0] RESET_HALF_SECOND = 16'd50;
    localparam logic [CFG_WIDTH-1:0] RESET_STEP_DELAY  = 16'd5;
    localparam logic [CFG_WIDTH-1:0] RESET_LONG_PRESS  = 16'd200;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] ticks_one_second;
        logic [CFG_WIDTH-1:0] ticks_half_second;
        logic [CFG_WIDTH-1:0] ticks_step_delay;
        logic [CFG_WIDTH-1:0] ticks_long_press;
    } cfg_t;

    typedef enum logic [5:0] {
        PH_WAIT_BTN     = 6'b000001,
        PH_WAIT_PGOOD   = 6'b000010,
        PH_WAIT_CARRIER = 6'b000100,
        PH_CPU_START    = 6'b001000,
        PH_CPU_NO_RST   = 6'b010000,
        PH_WORKING      = 6'b100000
    } phase_t;

    localparam logic [PHASE_WIDTH-1:0] CODE_WAIT_BTN     = 3'd0;
    localparam logic [PHASE_WIDTH-1:0] CODE_WAIT_PGOOD   = 3'd1;
    localparam logic [PHASE_WIDTH-1:0] CODE_WAIT_CARRIER = 3'd2;
    localparam logic [PHASE_WIDTH-1:0] CODE_CPU_START    = 3'd3;
    localparam logic [PHASE_WIDTH-1:0] CODE_CPU_NO_RST   = 3'd4;
    localparam logic [PHASE_WIDTH-1:0] CODE_WORKING      = 3'd5;

    typedef struct packed {
        logic boot_mode_pin;
        logic cpu_power;
        logic dcdc_enable;
        logic power_good_out;
        logic cpu_reset;
        logic enable_five_volt;
        logic led_status;
        logic led_power;
    } pins_t;

    localparam pins_t PINS_RESET = '{led_status: 1'b1, default: 1'b0};

    typedef struct packed {
        logic button_level;
        logic tick_pulse;
        logic power_on_request;
    } poll_t;

    typedef struct packed {
        logic                   led_power;
        logic                   led_status;
        logic                   enable_five_volt;
        logic                   cpu_reset;
        logic                   power_good_out;
        logic                   dcdc_enable;
        logic                   cpu_power;
        logic                   boot_mode_pin;
        logic [PHASE_WIDTH-1:0] phase;
    } status_t;

    function automatic logic [PHASE_WIDTH-1:0] phase_code(input phase_t ph);
        logic [PHASE_WIDTH-1:0] code;
        case (ph)
            PH_WAIT_BTN:     code = CODE_WAIT_BTN;
            PH_WAIT_PGOOD:   code = CODE_WAIT_PGOOD;
            PH_WAIT_CARRIER: code = CODE_WAIT_CARRIER;
            PH_CPU_START:    code = CODE_CPU_START;
            PH_CPU_NO_RST:   code = CODE_CPU_NO_RST;
            PH_WORKING:      code = CODE_WORKING;
            default:         code = CODE_WAIT_BTN;
        endcase
        return code;
    endfunction

endpackage

// ===== hdl/bps_stream_if.sv =====
// Valid/ready stream channel carrying one request payload.
interface bps_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/board_power_sequencer_core.sv =====
// Top level of the board power sequencer: request registers and handshakes.
//
// Each request on the poll channel carries the button level, a timebase tick
// and a power-on request. For every poll request the block returns exactly one
// request on the status channel with all pin levels and the sequencing phase.
// Timing registers are written through the plain configuration write port and
// should only be changed while no poll is outstanding.
// A poll is captured in an input register, processed against the sequencer
// state once the status output register can take a result, and lands in
// that register, from which the status channel offers it.
// One poll is accepted every cycle unless the receiver stalls; the rate is
// set by the state update between the input register and the status register.
// If the receiver stalls, the status register holds its request and the input
// register takes one more poll before the poll channel deasserts ready.
// Reset puts the sequencer in the wait-for-button phase with the status LED
// high, all other pins low, the timers idle and the registers at their
// default values.
module board_power_sequencer_core #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    bps_stream_if.sink                           poll,
    bps_stream_if.source                         status,
    input  logic                                 cfg_write_en,
    input  logic [bps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bps_pkg::CFG_WIDTH-1:0]       cfg_data
);
    bps_pkg::cfg_t    cfg;
    bps_pkg::status_t status_calc;

    logic             in_valid_reg;
    bps_pkg::poll_t   in_data_reg;
    logic             out_valid_reg;
    bps_pkg::status_t out_data_reg;
    logic             out_load;
    logic             step_en;

    assign out_load    = !out_valid_reg || status.ready;
    assign step_en     = in_valid_reg && out_load;
    assign poll.ready  = !in_valid_reg || step_en;

    bps_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    bps_seq_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .poll_data   (in_data_reg),
        .cfg         (cfg),
        .status_next (status_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (poll.valid && poll.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step_en)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (status.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll.valid && poll.ready)
        begin
            in_data_reg <= poll.data;
        end
        if (step_en)
        begin
            out_data_reg <= status_calc;
        end
    end

    assign status.valid = out_valid_reg;
    assign status.data  = out_data_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !status.ready) |-> !poll.ready)
        else $error("Poll accepted while both request registers are full.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(status.valid) |-> $past(in_valid_reg))
        else $error("Status request raised without a captured poll.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (status.valid && status.data.phase == bps_pkg::CODE_WORKING)
            |-> !status.data.cpu_reset)
        else $error("CPU held in reset while working.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (status.valid && status.data.phase != bps_pkg::CODE_WAIT_BTN)
            |-> status.data.enable_five_volt)
        else $error("5V supply off during the power-up sequence.");
`endif
endmodule

// ===== hdl/bps_cfg_regs.sv =====
// Configuration register bank with a plain write port.
module bps_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [bps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bps_pkg::CFG_WIDTH-1:0]       cfg_data,
    output bps_pkg::cfg_t                        cfg
);
    bps_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_one_second  <= bps_pkg::RESET_ONE_SECOND;
            cfg_reg.ticks_half_second <= bps_pkg::RESET_HALF_SECOND;
            cfg_reg.ticks_step_delay  <= bps_pkg::RESET_STEP_DELAY;
            cfg_reg.ticks_long_press  <= bps_pkg::RESET_LONG_PRESS;
        end
        else if (cfg_write_en)
        begin
            case (bps_pkg::cfg_index_t'(cfg_index))
                bps_pkg::CFG_ONE_SECOND:  cfg_reg.ticks_one_second  <= cfg_data;
                bps_pkg::CFG_HALF_SECOND: cfg_reg.ticks_half_second <= cfg_data;
                bps_pkg::CFG_STEP_DELAY:  cfg_reg.ticks_step_delay  <= cfg_data;
                bps_pkg::CFG_LONG_PRESS:  cfg_reg.ticks_long_press  <= cfg_data;
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule

// ===== hdl/bps_seq_core.sv =====
// Sequencer state, press timing and down-counters, updated once per request.
module bps_seq_core #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  bps_pkg::poll_t  poll_data,
    input  bps_pkg::cfg_t   cfg,
    output bps_pkg::status_t status_next
);
    localparam int unsigned CMP_WIDTH = 32;
    localparam logic [TIMER_WIDTH-1:0] ONE = {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
    localparam logic [TIMER_WIDTH-1:0] ZERO = '0;

    bps_pkg::phase_t         phase_reg, phase_next;
    bps_pkg::pins_t          pins_reg, pins_next;
    logic [TIMER_WIDTH-1:0]  led_timer_reg, led_timer_next;
    logic [TIMER_WIDTH-1:0]  blink_timer_reg, blink_timer_next;
    logic [TIMER_WIDTH-1:0]  seq_timer_reg, seq_timer_next;
    logic [TIMER_WIDTH-1:0]  tick_count_reg, tick_count_next;
    logic                    button_prev_reg, button_prev_next;
    logic [TIMER_WIDTH-1:0]  last_change_reg, last_change_next;

    logic [CMP_WIDTH-1:0]    one_ext, half_ext, step_ext;
    logic [TIMER_WIDTH-1:0]  load_one, load_half, load_step;
    logic [TIMER_WIDTH-1:0]  held;
    logic                    held_long, held_valid;

    // Timer loads keep only the low TIMER_WIDTH bits of each register.
    assign one_ext   = CMP_WIDTH'(cfg.ticks_one_second);
    assign half_ext  = CMP_WIDTH'(cfg.ticks_half_second);
    assign step_ext  = CMP_WIDTH'(cfg.ticks_step_delay);
    assign load_one  = one_ext[TIMER_WIDTH-1:0];
    assign load_half = half_ext[TIMER_WIDTH-1:0];
    assign load_step = step_ext[TIMER_WIDTH-1:0];

    assign held       = tick_count_reg - last_change_reg;
    assign held_long  = CMP_WIDTH'(held) >= CMP_WIDTH'(cfg.ticks_long_press);
    assign held_valid = CMP_WIDTH'(held) >= CMP_WIDTH'(cfg.ticks_step_delay);

    always_comb
    begin
        phase_next       = phase_reg;
        pins_next        = pins_reg;
        led_timer_next   = led_timer_reg;
        blink_timer_next = blink_timer_reg;
        seq_timer_next   = seq_timer_reg;
        tick_count_next  = tick_count_reg;
        button_prev_next = button_prev_reg;
        last_change_next = last_change_reg;

        // The power-on request is taken first, then the button, then the tick.
        if (poll_data.power_on_request && phase_next == bps_pkg::PH_WAIT_BTN)
        begin
            pins_next.led_power        = 1'b1;
            pins_next.enable_five_volt = 1'b1;
            pins_next.cpu_reset        = 1'b1;
            led_timer_next             = load_half;
            seq_timer_next             = load_step;
            phase_next                 = bps_pkg::PH_WAIT_PGOOD;
        end

        if (poll_data.button_level != button_prev_reg)
        begin
            button_prev_next = poll_data.button_level;
            last_change_next = tick_count_reg;
            if (poll_data.button_level)
            begin
                if (phase_next == bps_pkg::PH_WAIT_BTN)
                begin
                    if (held_long)
                    begin
                        pins_next.boot_mode_pin = 1'b1;
                        seq_timer_next          = load_one;
                    end
                    else if (held_valid)
                    begin
                        pins_next.led_power        = 1'b1;
                        pins_next.enable_five_volt = 1'b1;
                        pins_next.cpu_reset        = 1'b1;
                        led_timer_next             = load_half;
                        seq_timer_next             = load_step;
                        phase_next                 = bps_pkg::PH_WAIT_PGOOD;
                    end
                end
                else if (phase_next == bps_pkg::PH_WORKING && held_long)
                begin
                    pins_next.cpu_power        = 1'b0;
                    pins_next.dcdc_enable      = 1'b0;
                    pins_next.enable_five_volt = 1'b0;
                    pins_next.power_good_out   = 1'b0;
                    pins_next.boot_mode_pin    = 1'b0;
                    pins_next.led_status       = 1'b1;
                    phase_next                 = bps_pkg::PH_WAIT_BTN;
                    blink_timer_next           = load_one;
                end
            end
        end

        if (poll_data.tick_pulse)
        begin
            tick_count_next = tick_count_reg + ONE;

            if (led_timer_next != ZERO)
            begin
                led_timer_next = led_timer_next - ONE;
                if (led_timer_next == ZERO && phase_next == bps_pkg::PH_WORKING)
                begin
                    pins_next.led_status = ~pins_next.led_status;
                    led_timer_next       = load_one;
                end
            end

            if (blink_timer_next != ZERO)
            begin
                blink_timer_next = blink_timer_next - ONE;
                if (blink_timer_next == ZERO && phase_next == bps_pkg::PH_WAIT_BTN)
                begin
                    pins_next.led_power = ~pins_next.led_power;
                    blink_timer_next    = load_one;
                end
            end

            if (seq_timer_next != ZERO)
            begin
                seq_timer_next = seq_timer_next - ONE;
                if (seq_timer_next == ZERO)
                begin
                    case (phase_next)
                        bps_pkg::PH_WAIT_BTN:
                        begin
                            pins_next.led_power        = 1'b1;
                            pins_next.enable_five_volt = 1'b1;
                            pins_next.cpu_reset        = 1'b1;
                            led_timer_next             = load_half;
                            seq_timer_next             = load_step;
                            phase_next                 = bps_pkg::PH_WAIT_PGOOD;
                        end
                        bps_pkg::PH_WAIT_PGOOD:
                        begin
                            pins_next.led_status     = 1'b0;
                            pins_next.power_good_out = 1'b1;
                            seq_timer_next           = load_step;
                            phase_next               = bps_pkg::PH_WAIT_CARRIER;
                        end
                        bps_pkg::PH_WAIT_CARRIER:
                        begin
                            pins_next.dcdc_enable = 1'b1;
                            seq_timer_next        = load_step;
                            phase_next            = bps_pkg::PH_CPU_START;
                        end
                        bps_pkg::PH_CPU_START:
                        begin
                            pins_next.cpu_power = 1'b1;
                            pins_next.led_power = 1'b1;
                            seq_timer_next      = load_step;
                            phase_next          = bps_pkg::PH_CPU_NO_RST;
                        end
                        bps_pkg::PH_CPU_NO_RST:
                        begin
                            pins_next.cpu_reset = 1'b0;
                            pins_next.led_power = 1'b1;
                            seq_timer_next      = load_step;
                            phase_next          = bps_pkg::PH_WORKING;
                        end
                        default:
                        begin
                            seq_timer_next = ZERO;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= bps_pkg::PH_WAIT_BTN;
            pins_reg        <= bps_pkg::PINS_RESET;
            led_timer_reg   <= '0;
            blink_timer_reg <= '0;
            seq_timer_reg   <= '0;
            tick_count_reg  <= '0;
            button_prev_reg <= 1'b1;
            last_change_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            pins_reg        <= pins_next;
            led_timer_reg   <= led_timer_next;
            blink_timer_reg <= blink_timer_next;
            seq_timer_reg   <= seq_timer_next;
            tick_count_reg  <= tick_count_next;
            button_prev_reg <= button_prev_next;
            last_change_reg <= last_change_next;
        end
    end

    assign status_next.led_power        = pins_next.led_power;
    assign status_next.led_status       = pins_next.led_status;
    assign status_next.enable_five_volt = pins_next.enable_five_volt;
    assign status_next.cpu_reset        = pins_next.cpu_reset;
    assign status_next.power_good_out   = pins_next.power_good_out;
    assign status_next.dcdc_enable      = pins_next.dcdc_enable;
    assign status_next.cpu_power        = pins_next.cpu_power;
    assign status_next.boot_mode_pin    = pins_next.boot_mode_pin;
    assign status_next.phase            = bps_pkg::phase_code(phase_next);
endmodule

// ===== test/tb.sv =====
// Testbench of the board power sequencer core: every poll's pin levels and phase checked.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned HOLD_OFF_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write_en;
    logic [bps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [bps_pkg::CFG_WIDTH-1:0] cfg_data;

    bps_stream_if #(.payload_t(bps_pkg::poll_t)) poll_ch ();
    bps_stream_if #(.payload_t(bps_pkg::status_t)) status_ch ();

    board_power_sequencer_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .poll(poll_ch),
        .status(status_ch),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predicted sequencer state and its copy of the timing registers.
    bps_pkg::cfg_t timing;
    logic [bps_pkg::PHASE_WIDTH-1:0] seq_phase;
    logic [bps_pkg::CFG_WIDTH-1:0] led_count;
    logic [bps_pkg::CFG_WIDTH-1:0] blink_count;
    logic [bps_pkg::CFG_WIDTH-1:0] step_count;
    logic [bps_pkg::CFG_WIDTH-1:0] tick_now;
    logic [bps_pkg::CFG_WIDTH-1:0] press_stamp;
    logic btn_last;
    bps_pkg::pins_t pin_state;

    bps_pkg::status_t status_expected[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned polls_sent = 0;
    int unsigned hold_off_len = 0;
    bit idle_on = 1'b1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void reset_prediction();
        timing = '{bps_pkg::RESET_ONE_SECOND, bps_pkg::RESET_HALF_SECOND,
                   bps_pkg::RESET_STEP_DELAY, bps_pkg::RESET_LONG_PRESS};
        seq_phase = bps_pkg::CODE_WAIT_BTN;
        led_count = '0;
        blink_count = '0;
        step_count = '0;
        tick_now = '0;
        press_stamp = '0;
        btn_last = 1'b1;
        pin_state = bps_pkg::PINS_RESET;
    endfunction

    function automatic void power_up();
        if (seq_phase != bps_pkg::CODE_WAIT_BTN)
            return;
        pin_state.led_power = 1'b1;
        pin_state.enable_five_volt = 1'b1;
        pin_state.cpu_reset = 1'b1;
        led_count = timing.ticks_half_second;
        step_count = timing.ticks_step_delay;
        seq_phase = bps_pkg::CODE_WAIT_PGOOD;
    endfunction

    function automatic void power_down();
        if (seq_phase != bps_pkg::CODE_WORKING)
            return;
        pin_state.cpu_power = 1'b0;
        pin_state.dcdc_enable = 1'b0;
        pin_state.enable_five_volt = 1'b0;
        pin_state.power_good_out = 1'b0;
        pin_state.boot_mode_pin = 1'b0;
        pin_state.led_status = 1'b1;
        seq_phase = bps_pkg::CODE_WAIT_BTN;
        blink_count = timing.ticks_one_second;
    endfunction

    function automatic void step_done();
        case (seq_phase)
            bps_pkg::CODE_WAIT_BTN:
                power_up();
            bps_pkg::CODE_WAIT_PGOOD:
            begin
                pin_state.led_status = 1'b0;
                pin_state.power_good_out = 1'b1;
                step_count = timing.ticks_step_delay;
                seq_phase = bps_pkg::CODE_WAIT_CARRIER;
            end
            bps_pkg::CODE_WAIT_CARRIER:
            begin
                pin_state.dcdc_enable = 1'b1;
                step_count = timing.ticks_step_delay;
                seq_phase = bps_pkg::CODE_CPU_START;
            end
            bps_pkg::CODE_CPU_START:
            begin
                pin_state.cpu_power = 1'b1;
                pin_state.led_power = 1'b1;
                step_count = timing.ticks_step_delay;
                seq_phase = bps_pkg::CODE_CPU_NO_RST;
            end
            bps_pkg::CODE_CPU_NO_RST:
            begin
                pin_state.cpu_reset = 1'b0;
                pin_state.led_power = 1'b1;
                step_count = timing.ticks_step_delay;
                seq_phase = bps_pkg::CODE_WORKING;
            end
            default:
                ;
        endcase
    endfunction

    function automatic void button_released(input logic [bps_pkg::CFG_WIDTH-1:0] held);
        if (seq_phase == bps_pkg::CODE_WAIT_BTN)
        begin
            if (held >= timing.ticks_long_press)
            begin
                pin_state.boot_mode_pin = 1'b1;
                step_count = timing.ticks_one_second;
            end
            else if (held >= timing.ticks_step_delay)
                power_up();
        end
        else if (seq_phase == bps_pkg::CODE_WORKING && held >= timing.ticks_long_press)
            power_down();
    endfunction

    function automatic bps_pkg::status_t predict_status(input bps_pkg::poll_t item);
        bps_pkg::status_t result;
        if (item.power_on_request)
            power_up();
        if (item.button_level != btn_last)
        begin
            btn_last = item.button_level;
            if (item.button_level)
                button_released(tick_now - press_stamp);
            press_stamp = tick_now;
        end
        if (item.tick_pulse)
        begin
            tick_now = tick_now + 1'b1;
            if (led_count != 0)
            begin
                led_count = led_count - 1'b1;
                if (led_count == 0 && seq_phase == bps_pkg::CODE_WORKING)
                begin
                    pin_state.led_status = ~pin_state.led_status;
                    led_count = timing.ticks_one_second;
                end
            end
            if (blink_count != 0)
            begin
                blink_count = blink_count - 1'b1;
                if (blink_count == 0 && seq_phase == bps_pkg::CODE_WAIT_BTN)
                begin
                    pin_state.led_power = ~pin_state.led_power;
                    blink_count = timing.ticks_one_second;
                end
            end
            if (step_count != 0)
            begin
                step_count = step_count - 1'b1;
                if (step_count == 0)
                    step_done();
            end
        end
        result.led_power = pin_state.led_power;
        result.led_status = pin_state.led_status;
        result.enable_five_volt = pin_state.enable_five_volt;
        result.cpu_reset = pin_state.cpu_reset;
        result.power_good_out = pin_state.power_good_out;
        result.dcdc_enable = pin_state.dcdc_enable;
        result.cpu_power = pin_state.cpu_power;
        result.boot_mode_pin = pin_state.boot_mode_pin;
        result.phase = seq_phase;
        return result;
    endfunction

    function automatic void check_field(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_status
        bps_pkg::status_t want;
        bps_pkg::status_t got;
        if (rst_n && status_ch.valid && status_ch.ready)
        begin
            got = status_ch.data;
            if (status_expected.size() == 0)
            begin
                error_count++;
                $display("%0t: status expected none, actual %p", $time, got);
            end
            else
            begin
                want = status_expected.pop_front();
                check_field("led_power", want.led_power, got.led_power);
                check_field("led_status", want.led_status, got.led_status);
                check_field("enable_five_volt", want.enable_five_volt, got.enable_five_volt);
                check_field("cpu_reset", want.cpu_reset, got.cpu_reset);
                check_field("power_good_out", want.power_good_out, got.power_good_out);
                check_field("dcdc_enable", want.dcdc_enable, got.dcdc_enable);
                check_field("cpu_power", want.cpu_power, got.cpu_power);
                check_field("boot_mode_pin", want.boot_mode_pin, got.boot_mode_pin);
                if (want.phase !== got.phase)
                begin
                    error_count++;
                    $display("%0t: phase expected %0d, actual %0d", $time, want.phase,
                             got.phase);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The status receiver: random short stalls, or a long hold-off when one is asked for.
    initial
    begin
        status_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_len > 0)
            begin
                status_ch.ready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
                status_ch.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                status_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                status_ch.ready <= 1'b1;
            end
            else
                status_ch.ready <= 1'b1;
        end
    end

    task automatic send_poll(input logic btn, input logic tick, input logic req);
        bps_pkg::poll_t item;
        item.button_level = btn;
        item.tick_pulse = tick;
        item.power_on_request = req;
        poll_ch.valid <= 1'b1;
        poll_ch.data <= item;
        do
            @(posedge clk);
        while (!poll_ch.ready);
        status_expected.push_back(predict_status(item));
        polls_sent++;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            poll_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic settle();
        poll_ch.valid <= 1'b0;
        while (status_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timing(input bps_pkg::cfg_index_t idx,
                                input logic [bps_pkg::CFG_WIDTH-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            bps_pkg::CFG_ONE_SECOND:  timing.ticks_one_second = value;
            bps_pkg::CFG_HALF_SECOND: timing.ticks_half_second = value;
            bps_pkg::CFG_STEP_DELAY:  timing.ticks_step_delay = value;
            bps_pkg::CFG_LONG_PRESS:  timing.ticks_long_press = value;
            default:                  ;
        endcase
    endtask

    task automatic set_timing(input logic [bps_pkg::CFG_WIDTH-1:0] one_sec,
                              input logic [bps_pkg::CFG_WIDTH-1:0] half_sec,
                              input logic [bps_pkg::CFG_WIDTH-1:0] step_len,
                              input logic [bps_pkg::CFG_WIDTH-1:0] press_len);
        settle();
        write_timing(bps_pkg::CFG_ONE_SECOND, one_sec);
        write_timing(bps_pkg::CFG_HALF_SECOND, half_sec);
        write_timing(bps_pkg::CFG_STEP_DELAY, step_len);
        write_timing(bps_pkg::CFG_LONG_PRESS, press_len);
    endtask

    // Drives the sequencer back to waiting for the button with no power-up pending.
    task automatic return_to_wait();
        while (seq_phase != bps_pkg::CODE_WAIT_BTN || step_count != 0)
        begin
            if (seq_phase == bps_pkg::CODE_WORKING)
            begin
                send_poll(1'b0, 1'b0, 1'b0);
                repeat (timing.ticks_long_press) send_poll(1'b0, 1'b1, 1'b0);
                send_poll(1'b1, 1'b0, 1'b0);
            end
            else
                send_poll(1'b1, 1'b1, 1'b0);
        end
    endtask

    task automatic play_episode();
        int unsigned hold_ticks;
        int unsigned ticks_done;
        logic tick;
        case ($urandom_range(0, 3))
            0:       hold_ticks = $urandom_range(0, timing.ticks_step_delay);
            1:       hold_ticks = $urandom_range(timing.ticks_step_delay, timing.ticks_long_press);
            default: hold_ticks = timing.ticks_long_press + $urandom_range(0, 2);
        endcase
        ticks_done = 0;
        send_poll(1'b0, 1'b0, $urandom_range(0, 15) == 0);
        while (ticks_done < hold_ticks)
        begin
            tick = $urandom_range(0, 3) != 0;
            send_poll(1'b0, tick, $urandom_range(0, 15) == 0);
            if (tick)
                ticks_done++;
        end
        send_poll(1'b1, $urandom_range(0, 1) == 1, $urandom_range(0, 15) == 0);
        repeat ($urandom_range(0, 12))
            send_poll($urandom_range(0, 9) != 0, $urandom_range(0, 3) != 0,
                      $urandom_range(0, 15) == 0);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned first;
        first = polls_sent;
        while (polls_sent - first < count)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(3, 10))
                    send_poll($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1,
                              $urandom_range(0, 1) == 1);
            end
            else
                play_episode();
        end
    endtask

    task automatic test_after_reset();
        send_poll(1'b1, 1'b0, 1'b0);
        send_poll(1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_power_sequence();
        set_timing(16'd3, 16'd2, 16'd1, 16'd4);
        send_poll(1'b1, 1'b0, 1'b0);
        send_poll(1'b1, 1'b1, 1'b0);
        // A press of one tick powers up.
        send_poll(1'b0, 1'b0, 1'b0);
        send_poll(1'b0, 1'b1, 1'b0);
        send_poll(1'b1, 1'b0, 1'b0);
        send_poll(1'b1, 1'b0, 1'b1);
        // A press while sequencing is ignored, as is the status LED timer expiring early.
        send_poll(1'b0, 1'b1, 1'b0);
        send_poll(1'b1, 1'b1, 1'b0);
        send_poll(1'b1, 1'b1, 1'b0);
        send_poll(1'b1, 1'b1, 1'b0);
        send_poll(1'b1, 1'b1, 1'b0);
        send_poll(1'b1, 1'b1, 1'b1);
        // A long press while working powers down; the power LED then blinks.
        send_poll(1'b0, 1'b0, 1'b0);
        repeat (4) send_poll(1'b0, 1'b1, 1'b0);
        send_poll(1'b1, 1'b0, 1'b0);
        repeat (3) send_poll(1'b1, 1'b1, 1'b0);
        // A press released in the same tick is too short.
        send_poll(1'b0, 1'b0, 1'b0);
        send_poll(1'b1, 1'b0, 1'b0);
    endtask

    task automatic test_zero_half_second();
        return_to_wait();
        set_timing(16'd2, 16'd0, 16'd1, 16'd3);
        send_poll(1'b1, 1'b0, 1'b1);
        repeat (8) send_poll(1'b1, 1'b1, 1'b0);
    endtask

    task automatic test_random_setting(input bit all_ones);
        if (all_ones)
            set_timing(16'd1, 16'd1, 16'd1, 16'd1);
        else
            set_timing(16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)),
                       16'($urandom_range(1, 4)), 16'($urandom_range(2, 16)));
        run_random(250);
    endtask

    task automatic test_back_pressure();
        hold_off_len = HOLD_OFF_CYCLES;
        repeat (30)
            send_poll($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1,
                      $urandom_range(0, 7) == 0);
    endtask

    task automatic test_extreme_timing();
        return_to_wait();
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_poll(1'b0, 1'b0, 1'b0);
        repeat (3) send_poll(1'b0, 1'b1, 1'b0);
        send_poll(1'b1, 1'b0, 1'b0);
        repeat (3) send_poll(1'b1, 1'b1, 1'b0);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index <= bps_pkg::CFG_ONE_SECOND;
        cfg_data <= '0;
        poll_ch.valid <= 1'b0;
        poll_ch.data <= '0;
        reset_prediction();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_power_sequence();
        test_zero_half_second();
        test_random_setting(1'b1);
        test_random_setting(1'b0);
        test_random_setting(1'b0);
        test_back_pressure();
        test_extreme_timing();
        idle_on = 1'b0;
        test_random_setting(1'b0);
        settle();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
